FILE: src/lps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lps_pkg;

  localparam int CandW   = 16;
  localparam int CountW  = 14;
  localparam int StatusW = 2;

  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_ORDER = 2'd1;
  localparam logic [StatusW-1:0] ST_RANGE = 2'd2;

  // word handed from the front to the back through the queue
  typedef struct packed {
    logic [CandW-1:0]   cand;
    logic [StatusW-1:0] status;
  } q_item_t;

  // one result word
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  count;
    logic               is_prime;
  } res_t;

  // remainder unit status
  typedef struct packed {
    logic done;
    logic zero;
  } rem_res_t;

endpackage
`default_nettype wire

FILE: src/lps_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module lps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: src/lps_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module lps_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire lps_pkg::q_item_t item_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output lps_pkg::q_item_t      item_o
);
  import lps_pkg::*;

  localparam int AW = $clog2(DEPTH);

  q_item_t       slot_q [DEPTH];
  logic [AW:0]   wptr_q, rptr_q;
  logic          empty;

  assign empty   = (wptr_q == rptr_q);
  assign full_o  = (wptr_q[AW] != rptr_q[AW]) && (wptr_q[AW-1:0] == rptr_q[AW-1:0]);
  assign valid_o = !empty;
  assign item_o  = slot_q[rptr_q[AW-1:0]];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q[AW-1:0]] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/lps_rem.sv
`timescale 1ns / 1ps
`default_nettype none
module lps_rem (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [lps_pkg::CandW-1:0]     dividend_i,
  input  wire logic [lps_pkg::CandW-1:0]     divisor_i,
  output lps_pkg::rem_res_t                  res_o
);
  import lps_pkg::*;

  localparam int Steps = CandW / 2;
  localparam int SW    = $clog2(Steps);
  localparam logic [SW-1:0] LastStep = SW'(Steps - 1);

  logic [CandW-1:0] r_q, dvd_q, dvs_q;
  logic [CandW-1:0] r1, r2;
  logic [SW-1:0]    cnt_q;
  logic             busy_q;

  // one restoring step: shift in a dividend bit, subtract if it fits
  function automatic logic [CandW-1:0] rstep(input logic [CandW-1:0] r, input logic b,
                                             input logic [CandW-1:0] d);
    logic [CandW:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      rstep = CandW'(t - {1'b0, d});
    end else begin
      rstep = t[CandW-1:0];
    end
  endfunction

  assign r1 = rstep(r_q, dvd_q[CandW-1], dvs_q);
  assign r2 = rstep(r1, dvd_q[CandW-2], dvs_q);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q   <= '0;
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      r_q   <= r2;
      dvd_q <= {dvd_q[CandW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign res_o.done = !busy_q;
  assign res_o.zero = (r_q == '0);

endmodule
`default_nettype wire

FILE: src/lps_front.sv
`timescale 1ns / 1ps
`default_nettype none
module lps_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_valid_i,
  output logic                           s_ready_o,
  input  wire logic [lps_pkg::CandW-1:0] s_data_i,
  input  wire logic [lps_pkg::CandW-1:0] top_i,
  input  wire logic                      init_done_i,
  input  wire logic                      q_full_i,
  output logic                           push_o,
  output lps_pkg::q_item_t               item_o
);
  import lps_pkg::*;

  logic [CandW:0] expected_q, expected_d;
  logic           in_order;

  assign s_ready_o = init_done_i && !q_full_i;
  assign push_o    = s_valid_i && s_ready_o;
  assign in_order  = ({1'b0, s_data_i} == expected_q);

  always_comb begin
    item_o.cand = s_data_i;
    expected_d  = expected_q;
    if (!in_order) begin
      item_o.status = ST_ORDER;
    end else if (s_data_i > top_i) begin
      item_o.status = ST_RANGE;
    end else begin
      item_o.status = ST_OK;
      if (push_o) begin
        expected_d = expected_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q <= (CandW + 1)'(2);
    end else begin
      expected_q <= expected_d;
    end
  end

endmodule
`default_nettype wire

FILE: src/lps_back.sv
`timescale 1ns / 1ps
`default_nettype none
module lps_back #(
  parameter int MAX_VALUE   = 65536,
  parameter int PRIME_SLOTS = 8192
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [lps_pkg::CandW-1:0] top_i,
  input  wire logic                      q_valid_i,
  input  wire lps_pkg::q_item_t          q_item_i,
  output logic                           q_pop_o,
  output logic                           init_done_o,
  output logic                           m_valid_o,
  input  wire logic                      m_ready_i,
  output lps_pkg::res_t                  res_o
);
  import lps_pkg::*;

  localparam int MW = $clog2(MAX_VALUE);
  localparam int AW = $clog2(PRIME_SLOTS);
  localparam int CW = $clog2(PRIME_SLOTS + 1);
  localparam logic [MW-1:0] LastAddr = MW'(MAX_VALUE - 1);
  localparam logic [CW-1:0] Slots    = CW'(PRIME_SLOTS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MARK  = 3'd1;
  localparam logic [2:0] S_TREAD = 3'd2;
  localparam logic [2:0] S_TDATA = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [CandW-1:0] cand_q, cand_d;
  logic             prime_q, prime_d;
  logic [CW-1:0]    stored_q, stored_d;
  logic [CW-1:0]    j_q, j_d;
  logic [31:0]      prod_q, prod_d;
  logic             out_valid_q, out_valid_d;
  res_t             out_q, out_d;
  logic [MW-1:0]    clr_addr_q;
  logic             init_done_q;

  logic [CW+CountW-1:0] cnt_ext;
  logic [CountW-1:0]    cnt;
  logic [31:0]          cand_ext;
  logic                 out_free;

  logic             mark_we, mark_wdata, mark_rdata, mark_hit;
  logic [MW-1:0]    mark_waddr, mark_raddr;
  logic             tbl_we;
  logic [CandW-1:0] tbl_rdata;
  logic             rem_start;
  rem_res_t         rem;

  assign cnt_ext  = {{CountW{1'b0}}, stored_q};
  assign cnt      = cnt_ext[CountW-1:0];
  assign cand_ext = {{(32 - CandW){1'b0}}, q_item_i.cand};
  assign out_free = !out_valid_q || m_ready_i;

  // mark store: cleared by a sweep after reset, then written by the walk
  assign mark_raddr = cand_ext[MW-1:0];
  assign mark_waddr = init_done_q ? prod_q[MW-1:0] : clr_addr_q;
  assign mark_wdata = init_done_q;

  lps_ram #(.WIDTH(1), .DEPTH(MAX_VALUE)) u_marks (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (mark_wdata),
    .raddr_i (mark_raddr),
    .rdata_o (mark_rdata)
  );

  lps_ram #(.WIDTH(CandW), .DEPTH(PRIME_SLOTS)) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (stored_q[AW-1:0]),
    .wdata_i (cand_q),
    .raddr_i (j_q[AW-1:0]),
    .rdata_o (tbl_rdata)
  );

  lps_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (cand_q),
    .divisor_i  (tbl_rdata),
    .res_o      (rem)
  );

  assign mark_hit = (state_q == S_CMP) && (prod_q <= {16'b0, top_i});
  assign mark_we  = !init_done_q || mark_hit;

  always_comb begin
    state_d     = state_q;
    cand_d      = cand_q;
    prime_d     = prime_q;
    stored_d    = stored_q;
    j_d         = j_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && !m_ready_i;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    tbl_we      = 1'b0;
    rem_start   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i && out_free && init_done_q) begin
          q_pop_o = 1'b1;
          cand_d  = q_item_i.cand;
          if (q_item_i.status != ST_OK) begin
            out_valid_d    = 1'b1;
            out_d.is_prime = 1'b0;
            out_d.count    = cnt;
            out_d.status   = q_item_i.status;
          end else begin
            state_d = S_MARK;
          end
        end
      end
      S_MARK: begin
        prime_d = !mark_rdata;
        j_d     = '0;
        if (!mark_rdata && (stored_q < Slots)) begin
          tbl_we   = 1'b1;
          stored_d = stored_q + 1'b1;
        end
        state_d = S_TREAD;
      end
      S_TREAD: begin
        state_d = (j_q >= stored_q) ? S_DONE : S_TDATA;
      end
      S_TDATA: begin
        if (tbl_rdata == '0) begin
          state_d = S_DONE;
        end else begin
          prod_d    = cand_q * tbl_rdata;
          rem_start = 1'b1;
          state_d   = S_CMP;
        end
      end
      S_CMP: begin
        state_d = mark_hit ? S_DIV : S_DONE;
      end
      S_DIV: begin
        // stop after the first stored prime that divides the candidate
        if (rem.done) begin
          if (rem.zero) begin
            state_d = S_DONE;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = S_TREAD;
          end
        end
      end
      S_DONE: begin
        out_valid_d    = 1'b1;
        out_d.is_prime = prime_q;
        out_d.count    = cnt;
        out_d.status   = ST_OK;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cand_q  <= cand_d;
    prime_q <= prime_d;
    j_q     <= j_d;
    prod_q  <= prod_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stored_q    <= '0;
      out_valid_q <= 1'b0;
      clr_addr_q  <= '0;
      init_done_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stored_q    <= stored_d;
      out_valid_q <= out_valid_d;
      if (!init_done_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == LastAddr) begin
          init_done_q <= 1'b1;
        end
      end
    end
  end

  assign init_done_o = init_done_q;
  assign m_valid_o   = out_valid_q;
  assign res_o       = out_q;

endmodule
`default_nettype wire

FILE: src/linear_prime_sieve_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Rejected words (out of order, above limit) pass the queue and the result register, one per
// cycle while the back end is idle and the result side takes them. A sieved word walks the
// stored primes; each step is a table read, a multiply and a remainder (2 bits per cycle). The
// walk ends when a product passes the limit, the table runs out or a stored prime divides it.
// Input is taken until 2 words wait. After rst_ni the mark store is swept to zero; no input word
// is taken until the sweep ends. Limit resets to 65535, the next expected candidate to 2.
module linear_prime_sieve_top #(
  parameter int MAX_VALUE   = 65536,
  parameter int PRIME_SLOTS = 8192
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [15:0] candidate
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // [0] is_prime, [14:1] prime_count, [16:15] status
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i    // limit
);
  import lps_pkg::*;

  localparam logic [31:0] MaxM1 = 32'(MAX_VALUE - 1);

  logic [CandW-1:0] limit_q;
  logic [CandW-1:0] top;
  logic             init_done, q_full, q_push, q_pop, q_valid;
  q_item_t          push_item, head_item;
  res_t             res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 16'hFFFF;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // effective limit: the smaller of the register and the last store address
  assign top = ({16'b0, limit_q} > MaxM1) ? MaxM1[CandW-1:0] : limit_q;

  lps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .top_i       (top),
    .init_done_i (init_done),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .item_o      (push_item)
  );

  lps_fifo #(.DEPTH(2)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  lps_back #(.MAX_VALUE(MAX_VALUE), .PRIME_SLOTS(PRIME_SLOTS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .top_i       (top),
    .q_valid_i   (q_valid),
    .q_item_i    (head_item),
    .q_pop_o     (q_pop),
    .init_done_o (init_done),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {7'b0, res.status, res.count, res.is_prime};

  a_no_input_during_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> init_done)
    else $error("input word taken while the mark store is being cleared");

  a_pop_only_when_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("back end popped an empty queue");

  a_sweep_runs_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_done |=> init_done)
    else $error("mark sweep restarted without reset");

  a_result_status_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[16:15] == ST_OK || m_axis_tdata[16:15] == ST_ORDER ||
                       m_axis_tdata[16:15] == ST_RANGE) && (m_axis_tdata[23:17] == 7'b0))
    else $error("result word carries an undefined status");

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import lps_pkg::*;

  localparam int MaxValue    = 65536;
  localparam int PrimeSlots  = 8192;
  localparam int WalkDrain   = 700;     // idle stretch after the last result, before a limit write or the end
  localparam int HoldCycles  = 400;
  localparam int Watchdog    = 200000;  // covers the mark sweep after reset
  localparam int Phases      = 12;
  localparam int PhaseItems  = 115;
  localparam int HoldPhase   = 2;

  // Software copy of the sieve: marks, prime list, and the verdicts still to come out.
  class sieve_mirror;
    bit           composite [MaxValue];
    logic [15:0]  prime_list [PrimeSlots];
    int unsigned  stored;
    int unsigned  next_cand;
    int unsigned  limit_val;
    res_t         verdicts_due[$];
    int           mismatches;
    int           taken;
    int           sieved;
    int           checked;
    int           limit_writes;

    function new();
      stored       = 0;
      next_cand    = 2;
      limit_val    = 65535;
      mismatches   = 0;
      taken        = 0;
      sieved       = 0;
      checked      = 0;
      limit_writes = 0;
    endfunction

    function void set_limit(logic [15:0] value);
      limit_val = value;
      limit_writes++;
    endfunction

    function void accept_candidate(logic [15:0] cand);
      res_t        v;
      int unsigned top;
      int unsigned p;
      int unsigned prod;
      bit          prime;
      top        = limit_val;
      taken++;
      v.is_prime = 1'b0;
      v.count    = CountW'(stored);
      v.status   = ST_OK;
      if (cand != next_cand) begin
        v.status = ST_ORDER;
      end else if (cand > top) begin
        v.status = ST_RANGE;
      end else begin
        prime = !composite[cand];
        if (prime && stored < PrimeSlots) begin
          prime_list[stored] = cand;
          stored++;
        end
        // mark cand*p for each stored prime up to the smallest factor of cand, while cand*p is within the limit
        for (int j = 0; j < stored; j++) begin
          p    = prime_list[j];
          prod = cand * p;
          if (prod > top) break;
          composite[prod] = 1'b1;
          if (cand % p == 0) break;
        end
        next_cand  = (next_cand + 1) & 32'h1FFFF;
        v.is_prime = prime;
        v.count    = CountW'(stored);
        sieved++;
      end
      verdicts_due = {verdicts_due, v};
    endfunction

    function void compare_verdict(res_t got);
      res_t want;
      checked++;
      if (verdicts_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word: expected none, actual status %0d count %0d prime %0b",
                 $time, got.status, got.count, got.is_prime);
        return;
      end
      want = verdicts_due.pop_front();
      if (got.is_prime !== want.is_prime) begin
        mismatches++;
        $display("%0t: is_prime mismatch: expected %0b, actual %0b",
                 $time, want.is_prime, got.is_prime);
      end
      if (got.count !== want.count) begin
        mismatches++;
        $display("%0t: prime_count mismatch: expected %0d, actual %0d",
                 $time, want.count, got.count);
      end
      if (got.status !== want.status) begin
        mismatches++;
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, got.status);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [15:0] candidate
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [0] is_prime, [14:1] prime_count, [16:15] status
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  bit          tx_steady;
  bit          rx_steady;
  bit          hold_results;
  int          quiet_cycles;
  sieve_mirror mirror = new();

  linear_prime_sieve_top #(
    .MAX_VALUE   (MaxValue),
    .PRIME_SLOTS (PrimeSlots)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Mostly the next candidate in order, the rest random, one off it, or at either end of the range.
  function automatic logic [15:0] pick_candidate();
    int          r;
    logic [15:0] due;
    due = 16'(mirror.next_cand);
    r   = $urandom_range(0, 99);
    if (r < 85) return due;
    if (r < 91) return 16'($urandom);
    if (r < 95) return due + 16'd1;
    if (r < 98) return due - 16'd1;
    return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
  endfunction

  task automatic send_candidate(input logic [15:0] cand);
    int gap;
    gap = tx_steady ? 0 : idle_span();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= cand;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    mirror.accept_candidate(cand);
    @(negedge clk_i);
  endtask

  // Hold the input until every result is out, then idle for the WalkDrain stretch.
  task automatic wait_results_in();
    s_axis_tvalid <= 1'b0;
    while (mirror.verdicts_due.size() != 0) @(negedge clk_i);
    repeat (WalkDrain) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] value);
    wait_results_in();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    mirror.set_limit(value);
  endtask

  // Result side: random stalls, steady stretches, and one long hold on request.
  initial begin : result_sink
    int span;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_results) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_results = 1'b0;
      end else if (rx_steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        span = idle_span();
        m_axis_tready <= (span == 0);
        if (span > 1) repeat (span - 1) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      mirror.compare_verdict(res_t'(m_axis_tdata[16:0]));
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= Watchdog) begin
      $display("%0t: no word moved for %0d cycles", $time, Watchdog);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int          pick;
    int unsigned lim;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 16'h0000;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 16'h0000;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    hold_results  = 1'b0;
    quiet_cycles  = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // out of order before anything is sieved, then the first prime and a repeat
    send_candidate(16'h0000);
    send_candidate(16'hFFFF);
    send_candidate(16'd3);
    send_candidate(16'd2);
    send_candidate(16'd2);
    // lowest limit: the next candidate in order is rejected as above limit
    write_limit(16'd2);
    send_candidate(16'd3);
    send_candidate(16'd3);
    send_candidate(16'd1);
    write_limit(16'hFFFF);
    for (int c = 3; c <= 12; c++) send_candidate(16'(c));
    // shrink the limit mid-run so the mark for 26 is skipped for good
    write_limit(16'd13);
    send_candidate(16'd13);
    send_candidate(16'd14);
    write_limit(16'd100);

    for (int ph = 0; ph < Phases; ph++) begin
      pick = $urandom_range(0, 9);
      if (ph == 0 || ph == HoldPhase || pick < 5) lim = 65535;
      else if (pick < 7) lim = mirror.next_cand + $urandom_range(10, 80);
      else if (pick == 7) lim = $urandom_range(2, 65535);
      else if (pick == 8) lim = 2;
      else lim = mirror.next_cand * 3 / 2;
      write_limit(16'(lim));
      tx_steady = (ph % 4 == 1);
      rx_steady = (ph % 4 == 1);
      if (ph == HoldPhase) begin
        tx_steady    = 1'b1;
        hold_results = 1'b1;
      end
      repeat (PhaseItems) send_candidate(pick_candidate());
    end

    // a few stray candidates far from the expected one
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    send_candidate(16'hFFFF);
    send_candidate(16'h0000);
    send_candidate(16'h8000);

    wait_results_in();
    $display("Sieved %0d of %0d candidates across limit changes and stray words, %0d primes.",
             mirror.sieved, mirror.taken, mirror.stored);
    $display("Checked %0d results under %0d limit settings, %0d mismatches.",
             mirror.checked, mirror.limit_writes, mirror.mismatches);
    if (mirror.mismatches == 0 && mirror.verdicts_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
